// ===== rtl/rlbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rlbd_pkg
// shared types, codes and constants of the rgb led breathing dimmer
// ----------------------------------------------------------------------------
package rlbd_pkg;

    // parameter defaults
    localparam int NUM_CHANNELS_DEF = 3;
    localparam int LEVEL_BITS_DEF   = 4;

    // field widths
    localparam int OPCODE_W   = 2;
    localparam int CHAN_W     = 2;
    localparam int VALUE_W    = 8;
    localparam int NIBBLE_W   = 4;
    localparam int LEVEL_W    = 4;
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 8;

    // configuration registers
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int BASE_W      = 12;
    localparam int STEP_W      = 8;
    localparam int TICK_W      = 8;

    localparam logic [BASE_W-1:0] PERIOD_BASE_RST = BASE_W'(1000);
    localparam logic [STEP_W-1:0] PERIOD_STEP_RST = STEP_W'(100);
    localparam logic [TICK_W-1:0] TICK_PERIOD_RST = TICK_W'(50);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PERIOD_BASE = 2'd0,
        CFG_PERIOD_STEP = 2'd1,
        CFG_TICK_PERIOD = 2'd2
    } cfg_index_t;

    // ramp engine and serial divider
    localparam int RAMP_W     = 16;
    localparam int DIV_W      = 16;
    localparam int DIV_STEP_W = 5;
    localparam int PROD_W     = RAMP_W + TICK_W;
    localparam int NUM_W      = PROD_W + LEVEL_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_BRIGHTNESS = 2'd0,
        OP_DIRECT     = 2'd1,
        OP_TICK       = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_INACTIVE = 2'd0,
        MODE_ACTIVE   = 2'd2
    } channel_mode_t;

    typedef enum logic [1:0] {
        DIR_HOLD = 2'd0,
        DIR_DARK = 2'd1,
        DIR_UP   = 2'd2
    } ramp_dir_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT_SET,
        ST_LIMIT_WAIT,
        ST_MUL_COUNT,
        ST_MUL_PEAK,
        ST_LVL_START,
        ST_LVL_WAIT,
        ST_EMIT_LVL
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic arm;
        logic disarm_one;
        logic disarm_all;
        logic stop;
        logic div_limit;
        logic ramp_update;
        logic mul_count;
        logic mul_peak;
        logic div_level;
        logic emit_set;
        logic emit_level;
    } rlbd_cmd_t;

    // datapath to controller
    typedef struct packed {
        opcode_t op;
        logic    ch_ok;
        logic    code_nz;
        logic    ticking;
        logic    any_armed;
        logic    div_busy;
        logic    out_free;
        logic    last_ch;
    } rlbd_status_t;

endpackage

// ===== rtl/rlbd_div.sv =====
// ----------------------------------------------------------------------------
// rlbd_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rlbd_div
    import rlbd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIV_W-1:0]      rem_init,
    input  logic [DIV_W-1:0]      bits_init,
    input  logic [DIV_W-1:0]      divisor,
    input  logic [DIV_STEP_W-1:0] steps,
    output logic                  busy,
    output logic [DIV_W-1:0]      quot
);

    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [DIV_W-1:0]      bits_reg, bits_next;
    logic [DIV_W-1:0]      dvsr_reg, dvsr_next;
    logic [DIV_W-1:0]      quot_reg, quot_next;
    logic [DIV_STEP_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W:0]        trial;
    logic [DIV_W:0]        diff;
    logic                  q_bit;

    always_comb begin
        trial = {rem_reg, bits_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvsr_reg};
        q_bit = (trial >= {1'b0, dvsr_reg});

        rem_next  = rem_reg;
        bits_next = bits_reg;
        dvsr_next = dvsr_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            rem_next  = rem_init;
            bits_next = bits_init;
            dvsr_next = divisor;
            quot_next = '0;
            cnt_next  = steps;
        end else if (cnt_reg != '0) begin
            // remainder stays below the divisor, so the top bit drops out
            rem_next  = q_bit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            bits_next = {bits_reg[DIV_W-2:0], 1'b0};
            quot_next = {quot_reg[DIV_W-2:0], q_bit};
            cnt_next  = cnt_reg - DIV_STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        dvsr_reg <= dvsr_next;
        quot_reg <= quot_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

endmodule

// ===== rtl/rlbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlbd_ctrl
// sequencer: decodes a request and steps the datapath through a tick
// ----------------------------------------------------------------------------
module rlbd_ctrl
    import rlbd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  rlbd_status_t status,
    output rlbd_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                case (status.op)
                    OP_BRIGHTNESS: begin
                        if (status.ch_ok && !status.code_nz) state_next = ST_EMIT_SET;
                    end
                    OP_DIRECT: begin
                        if (status.ch_ok) state_next = ST_EMIT_SET;
                    end
                    OP_TICK: begin
                        if (status.ticking && status.any_armed) state_next = ST_LIMIT_WAIT;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_EMIT_SET: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            ST_LIMIT_WAIT: begin
                if (!status.div_busy) state_next = ST_MUL_COUNT;
            end
            ST_MUL_COUNT: state_next = ST_MUL_PEAK;
            ST_MUL_PEAK:  state_next = ST_LVL_START;
            ST_LVL_START: state_next = ST_LVL_WAIT;
            ST_LVL_WAIT: begin
                if (!status.div_busy) state_next = ST_EMIT_LVL;
            end
            ST_EMIT_LVL: begin
                if (status.out_free) state_next = status.last_ch ? ST_IDLE : ST_MUL_PEAK;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: cmd.accept = 1'b1;
            ST_DECODE: begin
                case (status.op)
                    OP_BRIGHTNESS: begin
                        cmd.arm        = status.ch_ok && status.code_nz;
                        cmd.disarm_one = status.ch_ok && !status.code_nz;
                    end
                    OP_DIRECT: cmd.disarm_all = status.ch_ok;
                    OP_TICK: begin
                        cmd.stop      = status.ticking && !status.any_armed;
                        cmd.div_limit = status.ticking && status.any_armed;
                    end
                    default: cmd = '0;
                endcase
            end
            ST_EMIT_SET:   cmd.emit_set    = status.out_free;
            ST_LIMIT_WAIT: cmd.ramp_update = !status.div_busy;
            ST_MUL_COUNT:  cmd.mul_count   = 1'b1;
            ST_MUL_PEAK:   cmd.mul_peak    = 1'b1;
            ST_LVL_START:  cmd.div_level   = 1'b1;
            ST_LVL_WAIT:   cmd = '0;
            ST_EMIT_LVL:   cmd.emit_level  = status.out_free;
            default:       cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // a new request never finds the divider still running
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !status.div_busy)
        else $error("request accepted while divider busy");

endmodule

// ===== rtl/rlbd_datapath.sv =====
// ----------------------------------------------------------------------------
// rlbd_datapath
// channel state, ramp counter, level arithmetic and result register
// ----------------------------------------------------------------------------
module rlbd_datapath
    import rlbd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int LEVEL_BITS   = LEVEL_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [S_TUSER_W-1:0]   s_tuser,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tlast,
    input  rlbd_cmd_t              cmd,
    output rlbd_status_t           status
);

    localparam int CIW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CIW-1:0] LastCh = CIW'(NUM_CHANNELS - 1);
    localparam logic [LEVEL_W-1:0] LevelMask =
        (LEVEL_BITS >= LEVEL_W) ? {LEVEL_W{1'b1}} : LEVEL_W'((1 << LEVEL_BITS) - 1);
    localparam int RcW = RAMP_W + 2;
    localparam int FsW = BASE_W + 1;

    // configuration
    logic [BASE_W-1:0] base_reg, base_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TICK_W-1:0] tick_reg, tick_next;

    // captured request
    opcode_t            op_reg;
    logic [CHAN_W-1:0]  ch_reg;
    logic [VALUE_W-1:0] value_reg;

    // engine state
    logic [LEVEL_W-1:0] peak_reg  [NUM_CHANNELS];
    logic [LEVEL_W-1:0] peak_next [NUM_CHANNELS];
    channel_mode_t      mode_reg  [NUM_CHANNELS];
    channel_mode_t      mode_next [NUM_CHANNELS];
    logic [RAMP_W-1:0]  count_reg, count_next;
    ramp_dir_t          dir_reg, dir_next;
    logic [RAMP_W-1:0]  fade_reg, fade_next;
    logic               ticking_reg, ticking_next;
    logic [CIW-1:0]     ch_idx_reg, ch_idx_next;

    // products
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [NUM_W-1:0]   num_reg, num_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]  out_ch_reg, out_ch_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;
    logic               out_last_reg, out_last_next;

    logic [CIW-1:0]      ch_sel;
    logic [NIBBLE_W-1:0] code;
    logic [FsW-1:0]      fade_sum;
    logic                any_active;
    logic                any_armed;
    logic                others_active;
    logic                out_free;
    logic [LEVEL_W-1:0]  level_val;

    // divider hookup
    logic                  div_start;
    logic [DIV_W-1:0]      div_rem_init;
    logic [DIV_W-1:0]      div_bits_init;
    logic [DIV_W-1:0]      div_divisor;
    logic [DIV_STEP_W-1:0] div_steps;
    logic                  div_busy;
    logic [DIV_W-1:0]      div_quot;

    // ramp update
    logic [RAMP_W-1:0]     limit_val;
    logic signed [RcW-1:0] limit_s;
    logic signed [RcW-1:0] ramp_c;
    logic [RAMP_W-1:0]     ramp_count_new;
    ramp_dir_t             ramp_dir_new;

    assign ch_sel   = CIW'(ch_reg);
    assign code     = value_reg[VALUE_W-1:NIBBLE_W];
    assign fade_sum = FsW'(base_reg) + FsW'(code) * FsW'(step_reg);
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        any_active    = 1'b0;
        any_armed     = 1'b0;
        others_active = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (mode_reg[i] == MODE_ACTIVE) any_active = 1'b1;
            if (mode_reg[i] != MODE_INACTIVE) any_armed = 1'b1;
            if (mode_reg[i] == MODE_ACTIVE && CIW'(i) != ch_sel) others_active = 1'b1;
        end
    end

    // limit check and turn of the shared ramp
    always_comb begin
        limit_val    = (tick_reg != '0) ? div_quot : '0;
        limit_s      = $signed({2'b00, limit_val});
        ramp_c       = $signed({2'b00, count_reg});
        ramp_dir_new = dir_reg;
        case (dir_reg)
            DIR_DARK: ramp_c = ramp_c - RcW'(1);
            DIR_UP:   ramp_c = ramp_c + RcW'(1);
            default:  ramp_c = $signed({2'b00, count_reg});
        endcase
        if (limit_s < ramp_c) begin
            ramp_c       = limit_s;
            ramp_dir_new = DIR_DARK;
        end
        if (ramp_c < $signed(RcW'(0))) begin
            ramp_c       = '0;
            ramp_dir_new = DIR_UP;
        end
        ramp_count_new = ramp_c[RAMP_W-1:0];
    end

    // divider operands: limit is fade / tick over all bits, level needs only
    // a nibble of quotient since count * tick never exceeds the fade period
    always_comb begin
        div_start = cmd.div_limit || cmd.div_level;
        if (cmd.div_level) begin
            div_rem_init  = num_reg[DIV_W+LEVEL_W-1:LEVEL_W];
            div_bits_init = {num_reg[LEVEL_W-1:0], {(DIV_W-LEVEL_W){1'b0}}};
            div_divisor   = fade_reg;
            div_steps     = DIV_STEP_W'(LEVEL_W);
        end else begin
            div_rem_init  = '0;
            div_bits_init = fade_reg;
            div_divisor   = DIV_W'(tick_reg);
            div_steps     = DIV_STEP_W'(DIV_W);
        end
    end

    rlbd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .rem_init  (div_rem_init),
        .bits_init (div_bits_init),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .busy      (div_busy),
        .quot      (div_quot)
    );

    assign level_val = (fade_reg != '0) ? (div_quot[LEVEL_W-1:0] & LevelMask) : '0;

    // state update
    always_comb begin
        base_next    = base_reg;
        step_next    = step_reg;
        tick_next    = tick_reg;
        peak_next    = peak_reg;
        mode_next    = mode_reg;
        count_next   = count_reg;
        dir_next     = dir_reg;
        fade_next    = fade_reg;
        ticking_next = ticking_reg;
        ch_idx_next  = ch_idx_reg;

        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_PERIOD_BASE: base_next = cfg_wdata[BASE_W-1:0];
                CFG_PERIOD_STEP: step_next = cfg_wdata[STEP_W-1:0];
                CFG_TICK_PERIOD: tick_next = cfg_wdata[TICK_W-1:0];
                default:         base_next = base_reg;
            endcase
        end

        if (cmd.arm) begin
            peak_next[ch_sel] = value_reg[LEVEL_W-1:0] & LevelMask;
            mode_next[ch_sel] = MODE_ACTIVE;
            count_next        = '0;
            dir_next          = DIR_UP;
            fade_next         = RAMP_W'(fade_sum);
            ticking_next      = ticking_reg || !others_active;
        end
        if (cmd.disarm_one) mode_next[ch_sel] = MODE_INACTIVE;
        if (cmd.disarm_all) begin
            for (int i = 0; i < NUM_CHANNELS; i++) mode_next[i] = MODE_INACTIVE;
        end
        if (cmd.stop) ticking_next = 1'b0;
        if (cmd.ramp_update) begin
            count_next  = ramp_count_new;
            dir_next    = ramp_dir_new;
            ch_idx_next = '0;
        end
        if (cmd.emit_level) ch_idx_next = CIW'(ch_idx_reg + 1'b1);
    end

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_ch_next    = out_ch_reg;
        out_level_next = out_level_reg;
        out_last_next  = out_last_reg;
        if (m_tready) out_valid_next = 1'b0;
        if (cmd.emit_set) begin
            out_valid_next = 1'b1;
            out_ch_next    = ch_reg;
            out_level_next = value_reg[LEVEL_W-1:0] & LevelMask;
            out_last_next  = 1'b1;
        end else if (cmd.emit_level) begin
            out_valid_next = 1'b1;
            out_ch_next    = CHAN_W'(ch_idx_reg);
            out_level_next = level_val;
            out_last_next  = (ch_idx_reg == LastCh);
        end
    end

    assign prod_next = PROD_W'(count_reg) * PROD_W'(tick_reg);
    assign num_next  = NUM_W'(prod_reg) * NUM_W'(peak_reg[ch_idx_reg]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= PERIOD_BASE_RST;
            step_reg      <= PERIOD_STEP_RST;
            tick_reg      <= TICK_PERIOD_RST;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                peak_reg[i] <= '0;
                mode_reg[i] <= MODE_INACTIVE;
            end
            count_reg     <= '0;
            dir_reg       <= DIR_HOLD;
            fade_reg      <= '0;
            ticking_reg   <= 1'b0;
            ch_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            base_reg      <= base_next;
            step_reg      <= step_next;
            tick_reg      <= tick_next;
            peak_reg      <= peak_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            dir_reg       <= dir_next;
            fade_reg      <= fade_next;
            ticking_reg   <= ticking_next;
            ch_idx_reg    <= ch_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_tvalid) begin
            op_reg    <= opcode_t'(s_tuser[OPCODE_W-1:0]);
            ch_reg    <= s_tdata[CHAN_W-1:0];
            value_reg <= s_tdata[CHAN_W+VALUE_W-1:CHAN_W];
        end
        if (cmd.mul_count) prod_reg <= prod_next;
        if (cmd.mul_peak) num_reg <= num_next;
        out_ch_reg    <= out_ch_next;
        out_level_reg <= out_level_next;
        out_last_reg  <= out_last_next;
    end

    always_comb begin
        status.op        = op_reg;
        status.ch_ok     = (32'(ch_reg) < NUM_CHANNELS);
        status.code_nz   = (code != '0);
        status.ticking   = ticking_reg;
        status.any_armed = any_armed;
        status.div_busy  = div_busy;
        status.out_free  = out_free;
        status.last_ch   = (ch_idx_reg == LastCh);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-CHAN_W-LEVEL_W){1'b0}}, out_level_reg, out_ch_reg};
    assign m_tlast  = out_last_reg;

    // an armed fade always has the engine running
    assert property (@(posedge aclk) disable iff (!aresetn)
        any_active |-> ticking_reg)
        else $error("active channel while engine stopped");

    // the ramp never passes the turning limit, which bounds the level division
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ramp_update |=>
            (PROD_W'(count_reg) * PROD_W'(tick_reg)) <= PROD_W'(fade_reg))
        else $error("ramp count beyond fade period");

    // a faded level never exceeds the channel peak
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_level |-> (level_val <= peak_reg[ch_idx_reg]))
        else $error("fade level above peak");

endmodule

// ===== rtl/rgb_led_breathing_dimmer.sv =====
// ----------------------------------------------------------------------------
// rgb_led_breathing_dimmer
// three-channel triangle fade engine driving rgb led levels
// ----------------------------------------------------------------------------
// One request at a time is taken on the s_ side. A brightness set or direct
// set that writes a level gives one result; arming a fade gives none. A
// tick while the engine runs with a channel armed gives one result per
// channel, the last one flagged on m_tlast. The single shared serial
// divider works out the turning limit (fade period / tick period), then
// count * tick * peak / fade period for each channel in turn. A stalled
// m_ side adds its stall to the request in flight; the finished result
// sits in an output register, so the next request is taken while it
// waits. Configuration writes land at once and are meant for idle periods
// only.
// ----------------------------------------------------------------------------
module rgb_led_breathing_dimmer
    import rlbd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int LEVEL_BITS   = LEVEL_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // configuration write: 0 period_base, 1 period_step, 2 tick_period
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    // request channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // channel[1:0], value[9:2], zero fill
    input  logic [S_TUSER_W-1:0]   s_tuser,   // opcode[1:0]

    // drive register writes
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // out_channel[1:0], out_level[5:2], zero fill
    output logic                   m_tlast    // final write caused by the request
);

    rlbd_cmd_t    cmd;
    rlbd_status_t status;

    // sequencer: decode, limit division, per-channel level loop
    rlbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    // channel state, ramp, divider and output register
    rlbd_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .LEVEL_BITS   (LEVEL_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    // ready only while the sequencer waits for a request
    assign s_tready = cmd.accept;

endmodule
